### hdl/msrng_pkg.sv
package msrng_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int FILL_STEPS  = TABLE_DEPTH + 8;
    localparam int CNT_W       = $clog2(FILL_STEPS);

    localparam int VAL_W  = 31;
    localparam int MUL_W  = 15;
    localparam int PROD_W = VAL_W + MUL_W;

    localparam logic [MUL_W-1:0] LEHMER_MUL = MUL_W'(16807);
    localparam logic [VAL_W-1:0] LEHMER_MOD = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] OUT_CAP    = VAL_W'(2147483389);

    // The slot divisor works out to a power of two, so the slot index is a bit field.
    localparam longint SLOT_DIV   = 64'd1 + (64'd2147483646 / longint'(TABLE_DEPTH));
    localparam int     SLOT_SHIFT = $clog2(SLOT_DIV);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_COMMIT
    } msrng_state_t;

    typedef struct packed {
        logic             load_seed;
        logic             fill_step;
        logic             fill_wr;
        logic [IDX_W-1:0] fill_idx;
        logic             fill_last;
        logic             draw_step;
        logic             read_slot;
        logic             commit;
    } msrng_cmd_t;

    typedef struct packed {
        logic filled;
        logic out_free;
    } msrng_status_t;

    // One step of x' = 16807 * x mod (2^31 - 1), folded over the Mersenne modulus.
    function automatic logic [VAL_W-1:0] lehmer_next(input logic [VAL_W-1:0] x);
        logic [PROD_W-1:0] prod;
        logic [VAL_W:0]    sum;
        prod = PROD_W'(x) * PROD_W'(LEHMER_MUL);
        sum  = {1'b0, prod[VAL_W-1:0]} + (VAL_W+1)'(prod[PROD_W-1:VAL_W]);
        if (sum >= {1'b0, LEHMER_MOD})
        begin
            sum = sum - {1'b0, LEHMER_MOD};
        end
        return sum[VAL_W-1:0];
    endfunction

endpackage

### hdl/msrng_req_if.sv
interface msrng_req_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink   (input valid, input reseed, output ready);
endinterface

### hdl/msrng_rsp_if.sv
interface msrng_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [msrng_pkg::VAL_W-1:0] uniform_value;

    modport source (output valid, output uniform_value, input ready);
    modport sink   (input valid, input uniform_value, output ready);
endinterface

### hdl/msrng_ram.sv
module msrng_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### hdl/msrng_ctrl.sv
module msrng_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_reseed,
    output logic                     in_ready,
    input  msrng_pkg::msrng_status_t status,
    output msrng_pkg::msrng_cmd_t    cmd
);
    msrng_pkg::msrng_state_t      state_reg, state_next;
    logic [msrng_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msrng_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.fill_idx = cnt_reg[msrng_pkg::IDX_W-1:0];
        unique case (state_reg)
            msrng_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_reseed || !status.filled)
                    begin
                        cmd.load_seed = 1'b1;
                        cnt_next      = msrng_pkg::CNT_W'(msrng_pkg::FILL_STEPS - 1);
                        state_next    = msrng_pkg::ST_FILL;
                    end
                    else
                    begin
                        // The table is ready, so the draw reads its slot right away.
                        cmd.read_slot = 1'b1;
                        cmd.draw_step = 1'b1;
                        state_next    = msrng_pkg::ST_COMMIT;
                    end
                end
            end
            msrng_pkg::ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                cmd.fill_wr   = (cnt_reg < msrng_pkg::CNT_W'(msrng_pkg::TABLE_DEPTH));
                if (cnt_reg == '0)
                begin
                    cmd.fill_last = 1'b1;
                    state_next    = msrng_pkg::ST_READ;
                end
                else
                begin
                    cnt_next = cnt_reg - msrng_pkg::CNT_W'(1);
                end
            end
            msrng_pkg::ST_READ:
            begin
                cmd.read_slot = 1'b1;
                cmd.draw_step = 1'b1;
                state_next    = msrng_pkg::ST_COMMIT;
            end
            msrng_pkg::ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = msrng_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msrng_pkg::ST_IDLE;
            end
        endcase
    end

    a_fill_ends_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msrng_pkg::ST_FILL && cnt_reg == '0)
            |=> state_reg == msrng_pkg::ST_READ)
        else $error("fill did not hand over to the draw");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == msrng_pkg::ST_IDLE)
        else $error("request beat taken outside idle");

    a_read_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_slot |=> state_reg == msrng_pkg::ST_COMMIT)
        else $error("table read not followed by commit");
endmodule

### hdl/msrng_dp.sv
module msrng_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [msrng_pkg::VAL_W-1:0]   cfg_wdata,
    input  msrng_pkg::msrng_cmd_t         cmd,
    output msrng_pkg::msrng_status_t      status,
    output logic                          ram_we,
    output logic [msrng_pkg::IDX_W-1:0]   ram_waddr,
    output logic [msrng_pkg::VAL_W-1:0]   ram_wdata,
    output logic                          ram_re,
    output logic [msrng_pkg::IDX_W-1:0]   ram_raddr,
    input  logic [msrng_pkg::VAL_W-1:0]   ram_rdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [msrng_pkg::VAL_W-1:0]   out_value
);
    logic [msrng_pkg::VAL_W-1:0] seed_reg;
    logic [msrng_pkg::VAL_W-1:0] lcg_reg, lcg_next;
    logic [msrng_pkg::VAL_W-1:0] shuf_reg;
    logic                        filled_reg;
    logic                        out_valid_reg;
    logic [msrng_pkg::VAL_W-1:0] out_value_reg;
    logic [msrng_pkg::VAL_W-1:0] seed_clean;
    logic [msrng_pkg::IDX_W-1:0] slot;

    assign lcg_next = msrng_pkg::lehmer_next(lcg_reg);
    assign slot     = msrng_pkg::IDX_W'(shuf_reg >> msrng_pkg::SLOT_SHIFT);

    // Zero is a fixed point of the generator and the modulus itself steps to zero.
    assign seed_clean = (seed_reg == '0 || seed_reg == msrng_pkg::LEHMER_MOD)
                        ? msrng_pkg::VAL_W'(1) : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= msrng_pkg::VAL_W'(1);
            filled_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                seed_reg <= cfg_wdata;
            end
            if (cmd.fill_last)
            begin
                filled_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
        begin
            lcg_reg <= seed_clean;
        end
        else if (cmd.fill_step || cmd.draw_step)
        begin
            lcg_reg <= lcg_next;
        end
        if (cmd.fill_last)
        begin
            shuf_reg <= lcg_next;
        end
        else if (cmd.commit)
        begin
            shuf_reg <= ram_rdata;
        end
        if (cmd.commit)
        begin
            out_value_reg <= (ram_rdata > msrng_pkg::OUT_CAP) ? msrng_pkg::OUT_CAP : ram_rdata;
        end
    end

    // The fill writes fresh generator values; a draw puts the stepped value into the slot it read.
    assign ram_we    = (cmd.fill_step && cmd.fill_wr) || cmd.commit;
    assign ram_waddr = cmd.fill_step ? cmd.fill_idx : slot;
    assign ram_wdata = cmd.fill_step ? lcg_next : lcg_reg;
    assign ram_re    = cmd.read_slot;
    assign ram_raddr = slot;

    assign status.filled   = filled_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

    a_read_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_slot |-> filled_reg)
        else $error("table read before it was filled");

    a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("table read and written in the same cycle");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg && shuf_reg == $past(ram_rdata))
        else $error("committed draw not presented");

    a_fill_sets_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_last |=> filled_reg && shuf_reg == lcg_reg)
        else $error("fill did not seed the shuffle output");
endmodule

### hdl/minimal_standard_rng_with_shuffle_core.sv
// Channel  | Direction | Payload                  | Beat taken when
// req      | in        | reseed (1 bit)           | req.valid && req.ready
// rsp      | out       | uniform_value (31 bits)  | rsp.valid && rsp.ready
// cfg      | in        | cfg_wdata: seed (31 bits)| cfg_wen
//
// A plain draw reads the shuffle table on the request beat, then commits in ST_COMMIT once the output register is free.
// A reseed, or the first request after reset, adds a seed load and 40 generator steps (ST_FILL) before ST_READ.
// The draw rate is set by the table's registered read, whose data picks the next slot.
// Reset clears control and loads seed with 1; the table holds nothing until the first fill.
// A result waits in the output register while the next request beat is taken; only the
// commit of the following draw waits on rsp.ready.
module minimal_standard_rng_with_shuffle_core (
    input  logic                        clk,
    input  logic                        rst_n,
    msrng_req_if.sink                   req,
    msrng_rsp_if.source                 rsp,
    input  logic                        cfg_wen,
    input  logic [msrng_pkg::VAL_W-1:0] cfg_wdata
);
    msrng_pkg::msrng_cmd_t       cmd;
    msrng_pkg::msrng_status_t    status;
    logic                        ram_we;
    logic [msrng_pkg::IDX_W-1:0] ram_waddr;
    logic [msrng_pkg::VAL_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [msrng_pkg::IDX_W-1:0] ram_raddr;
    logic [msrng_pkg::VAL_W-1:0] ram_rdata;

    msrng_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_reseed (req.reseed),
        .in_ready  (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    msrng_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_value (rsp.uniform_value)
    );

    msrng_ram #(
        .WIDTH (msrng_pkg::VAL_W),
        .DEPTH (msrng_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

### sim/tb_minimal_standard_rng_with_shuffle_core.sv
class draw_scoreboard;
    bit [msrng_pkg::VAL_W-1:0] seed = 31'd1;
    bit [msrng_pkg::VAL_W-1:0] lcg = 31'd1;
    bit [msrng_pkg::VAL_W-1:0] shuffle_out = '0;
    bit [msrng_pkg::VAL_W-1:0] slots [msrng_pkg::TABLE_DEPTH];
    bit                        table_valid = 1'b0;
    bit [msrng_pkg::VAL_W-1:0] expected_draws [$];
    int                        mismatches = 0;

    function bit [msrng_pkg::VAL_W-1:0] park_miller_step(bit [msrng_pkg::VAL_W-1:0] x);
        longint unsigned prod;
        prod = longint'(x) * 64'd16807;
        return msrng_pkg::VAL_W'(prod % 64'd2147483647);
    endfunction

    // Warm-up: the first eight generator steps are discarded, the rest fill the
    // slots from the top down.
    function void load_table();
        bit [msrng_pkg::VAL_W-1:0] x;
        x = seed;
        if (x == '0 || x == '1)
        begin
            x = 31'd1;
        end
        for (int s = msrng_pkg::TABLE_DEPTH + 7; s >= 0; s--)
        begin
            x = park_miller_step(x);
            if (s < msrng_pkg::TABLE_DEPTH)
            begin
                slots[s] = x;
            end
        end
        lcg = x;
        shuffle_out = slots[0];
        table_valid = 1'b1;
    endfunction

    function void note_request(bit reseed);
        longint unsigned slot;
        if (reseed || !table_valid)
        begin
            load_table();
        end
        lcg = park_miller_step(lcg);
        slot = longint'(shuffle_out) /
               (64'd1 + 64'd2147483646 / longint'(msrng_pkg::TABLE_DEPTH));
        if (slot >= msrng_pkg::TABLE_DEPTH)
        begin
            slot = msrng_pkg::TABLE_DEPTH - 1;
        end
        shuffle_out = slots[slot];
        slots[slot] = lcg;
        if (shuffle_out > msrng_pkg::OUT_CAP)
        begin
            expected_draws.push_back(msrng_pkg::OUT_CAP);
        end
        else
        begin
            expected_draws.push_back(shuffle_out);
        end
    endfunction

    function void check_draw(bit [msrng_pkg::VAL_W-1:0] got);
        bit [msrng_pkg::VAL_W-1:0] want;
        if (expected_draws.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected draw: uniform_value=%0d", got);
            end
            return;
        end
        want = expected_draws.pop_front();
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("draw mismatch: uniform_value expected %0d, got %0d", want, got);
            end
        end
    endfunction
endclass

module tb_minimal_standard_rng_with_shuffle_core;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_LATER = 60;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_wen;
    logic [msrng_pkg::VAL_W-1:0] cfg_wdata;
    bit                          quiet = 1'b0;
    int                          idle_cycles = 0;
    draw_scoreboard              sb;

    msrng_req_if req_ch ();
    msrng_rsp_if rsp_ch ();

    minimal_standard_rng_with_shuffle_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result beats go straight to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid && rsp_ch.ready)
        begin
            sb.check_draw(rsp_ch.uniform_value);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("tb_minimal_standard_rng_with_shuffle_core: FAIL");
                $finish;
            end
        end
    end

    // Receiver back-pressure in bursts; none once the run turns quiet.
    initial
    begin
        int hold;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 16) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic draw(bit reseed);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            req_ch.valid <= 1'b0;
            req_ch.reseed <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.reseed <= reseed;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(reseed);
    endtask

    // Every request yields one beat, so an empty queue means the core is idle.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.expected_draws.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_seed(bit [msrng_pkg::VAL_W-1:0] value);
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        cfg_wdata <= msrng_pkg::VAL_W'($urandom);
        sb.seed = value;
    endtask

    initial
    begin
        bit [msrng_pkg::VAL_W-1:0] phase_seed;
        int                        phase_len;
        sb = new;
        rst_n <= 1'b0;
        cfg_wen <= 1'b0;
        cfg_wdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.reseed <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first request after reset must fill from the reset seed of 1.
        draw(1'b0);
        draw(1'b0);
        draw(1'b0);
        draw(1'b1);
        draw(1'b1);
        draw(1'b0);
        wait_drained();
        write_seed(31'd2147483646);
        draw(1'b1);
        draw(1'b0);
        draw(1'b0);
        wait_drained();
        // Zero and all-ones are not valid generator states and load as 1.
        write_seed('0);
        draw(1'b1);
        draw(1'b0);
        wait_drained();
        write_seed('1);
        draw(1'b1);
        draw(1'b0);
        wait_drained();
        // A seed write alone must not disturb the running sequence.
        write_seed(31'd12345);
        draw(1'b0);
        draw(1'b0);
        draw(1'b1);
        draw(1'b0);
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 5))
                0: phase_seed = 31'd1;
                1: phase_seed = 31'd2147483646;
                2: phase_seed = '0;
                3: phase_seed = '1;
                default: phase_seed = msrng_pkg::VAL_W'($urandom);
            endcase
            write_seed(phase_seed);
            quiet = (phase == 5);
            phase_len = 250;
            draw($urandom_range(0, 3) != 0);
            for (int n = 1; n < phase_len; n++)
            begin
                draw($urandom_range(0, 24) == 0);
            end
            wait_drained();
        end

        repeat (SETTLE_LATER) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_draws.size() == 0)
        begin
            $display("tb_minimal_standard_rng_with_shuffle_core: PASS");
        end
        else
        begin
            $display("tb_minimal_standard_rng_with_shuffle_core: FAIL");
        end
        $finish;
    end
endmodule

### filelist.f
hdl/msrng_pkg.sv
hdl/msrng_req_if.sv
hdl/msrng_rsp_if.sv
hdl/msrng_ram.sv
hdl/msrng_ctrl.sv
hdl/msrng_dp.sv
hdl/minimal_standard_rng_with_shuffle_core.sv
sim/tb_minimal_standard_rng_with_shuffle_core.sv
